>>> sv/dgdfs_pkg.sv
// Shared constants and types for the dependency graph walker.
package dgdfs_pkg;

    localparam int MAX_NODES = 64;
    localparam int MAX_EDGES = 256;

    localparam int NODE_W  = $clog2(MAX_NODES);
    localparam int CNT_W   = $clog2(MAX_NODES + 1);
    localparam int EADDR_W = $clog2(MAX_EDGES);
    localparam int EDGE_W  = $clog2(MAX_EDGES + 1);
    localparam int TIME_W  = 8;

    localparam logic [EDGE_W-1:0] EDGE_NULL = EDGE_W'(MAX_EDGES);
    localparam logic [CNT_W-1:0]  NODE_LIMIT = CNT_W'(MAX_NODES);

    // input item kinds
    localparam logic [1:0] KIND_FLAG  = 2'd0;
    localparam logic [1:0] KIND_EDGE  = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    // node colors stored in the color memory; an unwritten entry is white
    localparam logic [1:0] COLOR_WHITE = 2'd0;
    localparam logic [1:0] COLOR_GRAY  = 2'd1;
    localparam logic [1:0] COLOR_BLACK = 2'd2;

    typedef struct packed {
        logic              flag;
        logic [EDGE_W-1:0] head;
        logic [EDGE_W-1:0] tail;
    } node_entry_t;

    typedef struct packed {
        logic [1:0]        color;
        logic [TIME_W-1:0] disc;
    } color_entry_t;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [EDGE_W-1:0] cur;
        logic [TIME_W-1:0] disc;
    } stack_entry_t;

endpackage

>>> sv/dgdfs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module dgdfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> sv/dependency_graph_dfs_postorder.sv
// Top level of the dependency graph walker: graph load and depth-first post-order search.
//
// Set flag and append edge are each a read-modify-write of the node table memory; an
// append to a source that already has edges adds a step that links the new edge behind
// the old tail. Clear graph and an append to a full edge pool finish in the accepting
// cycle. A start beat walks the graph with an explicit stack held in memory, trying each
// root in turn, discovering nodes, visiting edges and finishing nodes, then closes the run.
// A bad edge target ends the run; an earlier result still held is sent before the error
// beat. These steps follow from the registered read data of the node, color, edge and
// stack memories. busy falls in the same cycle as the last result strobe of a run. Results
// come one per strobe on result_valid and must be taken in the cycle they appear; the
// receiver cannot stall them.
module dependency_graph_dfs_postorder (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               kind,
    input  logic [dgdfs_pkg::NODE_W-1:0] node_index,
    input  logic                     is_formula,
    input  logic [dgdfs_pkg::NODE_W-1:0] target_index,
    input  logic                     cfg_we,
    input  logic [6:0]               cfg_data,
    output logic                     result_valid,
    output logic [dgdfs_pkg::NODE_W-1:0] finished_node,
    output logic [dgdfs_pkg::TIME_W-1:0] discover_time,
    output logic [dgdfs_pkg::TIME_W-1:0] finish_time,
    output logic                     error,
    output logic                     last
);
    import dgdfs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_LDFLAG, S_LDEDGE, S_LDLINK, S_ROOT, S_ROOTCHK, S_PUSH,
        S_STEP, S_POP, S_EDGE, S_TGT, S_ERR
    } state_t;

    state_t             state_reg;
    logic [6:0]         node_count_reg;
    logic [MAX_NODES-1:0] node_vld_reg;
    logic [MAX_NODES-1:0] col_vld_reg;
    logic               node_rd_ok_reg;
    logic               col_rd_ok_reg;
    logic [EDGE_W-1:0]  edges_used_reg;
    logic [EDGE_W-1:0]  link_e_reg;
    logic [EADDR_W-1:0] link_addr_reg;
    logic [NODE_W-1:0]  ld_node_reg;
    logic               ld_flag_reg;
    logic [NODE_W-1:0]  ld_tgt_reg;
    logic [CNT_W-1:0]   root_reg;
    logic [NODE_W-1:0]  push_node_reg;
    logic [NODE_W-1:0]  tgt_reg;
    logic [TIME_W-1:0]  time_reg;
    logic [NODE_W-1:0]  sp_reg;
    logic               top_valid_reg;
    logic [NODE_W-1:0]  top_node_reg;
    logic [EDGE_W-1:0]  top_cur_reg;
    logic [TIME_W-1:0]  top_disc_reg;
    logic               pend_valid_reg;
    logic [NODE_W-1:0]  pend_node_reg;
    logic [TIME_W-1:0]  pend_disc_reg;
    logic [TIME_W-1:0]  pend_fin_reg;
    logic               res_valid_reg;
    logic [NODE_W-1:0]  res_node_reg;
    logic [TIME_W-1:0]  res_disc_reg;
    logic [TIME_W-1:0]  res_fin_reg;
    logic               res_err_reg;
    logic               res_last_reg;

    logic [CNT_W-1:0]   n_eff;
    node_entry_t        node_rd, node_cur, node_wdata;
    logic               node_we;
    logic [NODE_W-1:0]  node_waddr, node_raddr;
    color_entry_t       col_rd, col_wdata;
    logic               col_we;
    logic [NODE_W-1:0]  col_waddr, col_raddr;
    logic [1:0]         col_now;
    stack_entry_t       stk_rd, stk_wdata;
    logic               stk_we;
    logic [NODE_W-1:0]  stk_raddr;
    logic               nxt_we, tgt_we;
    logic [EADDR_W-1:0] nxt_waddr;
    logic [EDGE_W-1:0]  nxt_wdata;
    logic [EDGE_W-1:0]  pool_nxt;
    logic [NODE_W-1:0]  pool_tgt;

    // saturate the node count into 1..MAX_NODES
    always_comb
    begin
        if (node_count_reg == 7'd0)
            n_eff = CNT_W'(1);
        else if (CNT_W'(node_count_reg) > NODE_LIMIT)
            n_eff = NODE_LIMIT;
        else
            n_eff = CNT_W'(node_count_reg);
    end

    // node entry as seen through its valid bit
    always_comb
    begin
        node_cur = node_rd;
        if (!node_rd_ok_reg)
        begin
            node_cur.flag = 1'b0;
            node_cur.head = EDGE_NULL;
            node_cur.tail = EDGE_NULL;
        end
        col_now = col_rd_ok_reg ? col_rd.color : COLOR_WHITE;
    end

    // memory addresses and write strobes
    always_comb
    begin
        node_we    = 1'b0;
        node_waddr = ld_node_reg;
        node_wdata = node_cur;
        node_raddr = node_index;
        col_we     = 1'b0;
        col_waddr  = push_node_reg;
        col_wdata  = '{color: COLOR_GRAY, disc: time_reg + 8'd1};
        col_raddr  = root_reg[NODE_W-1:0];
        stk_we     = 1'b0;
        stk_wdata  = '{node: top_node_reg, cur: top_cur_reg, disc: top_disc_reg};
        stk_raddr  = sp_reg - NODE_W'(1);
        nxt_we     = 1'b0;
        nxt_waddr  = edges_used_reg[EADDR_W-1:0];
        nxt_wdata  = EDGE_NULL;
        tgt_we     = 1'b0;
        unique case (state_reg)
            S_LDFLAG:
            begin
                node_we         = 1'b1;
                node_wdata.flag = ld_flag_reg;
            end
            S_LDEDGE:
            begin
                node_we         = 1'b1;
                node_wdata.tail = edges_used_reg;
                if (node_cur.tail == EDGE_NULL)
                    node_wdata.head = edges_used_reg;
                nxt_we = 1'b1;
                tgt_we = 1'b1;
            end
            S_LDLINK:
            begin
                nxt_we    = 1'b1;
                nxt_waddr = link_addr_reg;
                nxt_wdata = link_e_reg;
            end
            S_ROOTCHK:
            begin
                node_raddr = root_reg[NODE_W-1:0];
            end
            S_PUSH:
            begin
                col_we = 1'b1;
                stk_we = top_valid_reg;
            end
            S_STEP:
            begin
                if (top_valid_reg && top_cur_reg == EDGE_NULL)
                begin
                    col_we    = 1'b1;
                    col_waddr = top_node_reg;
                    col_wdata = '{color: COLOR_BLACK, disc: top_disc_reg};
                end
            end
            S_EDGE:
            begin
                col_raddr = pool_tgt;
            end
            S_TGT:
            begin
                node_raddr = tgt_reg;
            end
            default:
            begin
            end
        endcase
    end

    dgdfs_ram #(.WIDTH($bits(node_entry_t)), .DEPTH(MAX_NODES)) u_node_ram (
        .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
        .raddr(node_raddr), .rdata(node_rd)
    );

    dgdfs_ram #(.WIDTH($bits(color_entry_t)), .DEPTH(MAX_NODES)) u_color_ram (
        .clk(clk), .we(col_we), .waddr(col_waddr), .wdata(col_wdata),
        .raddr(col_raddr), .rdata(col_rd)
    );

    dgdfs_ram #(.WIDTH($bits(stack_entry_t)), .DEPTH(MAX_NODES)) u_stack_ram (
        .clk(clk), .we(stk_we), .waddr(sp_reg), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rd)
    );

    dgdfs_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_next_ram (
        .clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
        .raddr(top_cur_reg[EADDR_W-1:0]), .rdata(pool_nxt)
    );

    dgdfs_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGES)) u_target_ram (
        .clk(clk), .we(tgt_we), .waddr(edges_used_reg[EADDR_W-1:0]), .wdata(ld_tgt_reg),
        .raddr(top_cur_reg[EADDR_W-1:0]), .rdata(pool_tgt)
    );

    // sequencer, valid bits and registered result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= 7'd64;
            node_vld_reg   <= '0;
            col_vld_reg    <= '0;
            node_rd_ok_reg <= 1'b0;
            col_rd_ok_reg  <= 1'b0;
            edges_used_reg <= '0;
            time_reg       <= '0;
            sp_reg         <= '0;
            top_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            res_err_reg    <= 1'b0;
            res_last_reg   <= 1'b0;
            root_reg       <= '0;
        end
        else
        begin
            node_rd_ok_reg <= node_vld_reg[node_raddr];
            col_rd_ok_reg  <= col_vld_reg[col_raddr];
            res_valid_reg  <= 1'b0;
            if (cfg_we)
                node_count_reg <= cfg_data;
            if (node_we)
                node_vld_reg[node_waddr] <= 1'b1;
            if (col_we)
                col_vld_reg[col_waddr] <= 1'b1;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        ld_node_reg <= node_index;
                        ld_flag_reg <= is_formula;
                        ld_tgt_reg  <= target_index;
                        unique case (kind)
                            KIND_FLAG:
                                state_reg <= S_LDFLAG;
                            KIND_EDGE:
                            begin
                                if (edges_used_reg != EDGE_NULL)
                                    state_reg <= S_LDEDGE;
                            end
                            KIND_START:
                            begin
                                col_vld_reg    <= '0;
                                time_reg       <= '0;
                                root_reg       <= '0;
                                sp_reg         <= '0;
                                top_valid_reg  <= 1'b0;
                                pend_valid_reg <= 1'b0;
                                state_reg      <= S_ROOT;
                            end
                            KIND_CLEAR:
                            begin
                                node_vld_reg   <= '0;
                                edges_used_reg <= '0;
                            end
                        endcase
                    end
                end
                S_LDFLAG:
                    state_reg <= S_IDLE;
                S_LDEDGE:
                begin
                    link_e_reg     <= edges_used_reg;
                    link_addr_reg  <= node_cur.tail[EADDR_W-1:0];
                    edges_used_reg <= edges_used_reg + EDGE_W'(1);
                    state_reg      <= (node_cur.tail == EDGE_NULL) ? S_IDLE : S_LDLINK;
                end
                S_LDLINK:
                    state_reg <= S_IDLE;
                S_ROOT:
                begin
                    if (root_reg == n_eff)
                    begin
                        // end of run: release the held result as the final beat
                        if (pend_valid_reg)
                        begin
                            res_valid_reg <= 1'b1;
                            res_node_reg  <= pend_node_reg;
                            res_disc_reg  <= pend_disc_reg;
                            res_fin_reg   <= pend_fin_reg;
                            res_err_reg   <= 1'b0;
                            res_last_reg  <= 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                    else
                        state_reg <= S_ROOTCHK;
                end
                S_ROOTCHK:
                begin
                    if (col_now == COLOR_WHITE)
                    begin
                        push_node_reg <= root_reg[NODE_W-1:0];
                        state_reg     <= S_PUSH;
                    end
                    else
                    begin
                        root_reg  <= root_reg + CNT_W'(1);
                        state_reg <= S_ROOT;
                    end
                end
                S_PUSH:
                begin
                    // turn the node gray and make it the stack top
                    time_reg <= time_reg + 8'd1;
                    if (top_valid_reg)
                        sp_reg <= sp_reg + NODE_W'(1);
                    top_valid_reg <= 1'b1;
                    top_node_reg  <= push_node_reg;
                    top_disc_reg  <= time_reg + 8'd1;
                    top_cur_reg   <= node_cur.flag ? node_cur.head : EDGE_NULL;
                    state_reg     <= S_STEP;
                end
                S_STEP:
                begin
                    if (!top_valid_reg)
                    begin
                        root_reg  <= root_reg + CNT_W'(1);
                        state_reg <= S_ROOT;
                    end
                    else if (top_cur_reg != EDGE_NULL)
                        state_reg <= S_EDGE;
                    else
                    begin
                        // finish the top node; hold it until the next one decides last
                        time_reg <= time_reg + 8'd1;
                        if (pend_valid_reg)
                        begin
                            res_valid_reg <= 1'b1;
                            res_node_reg  <= pend_node_reg;
                            res_disc_reg  <= pend_disc_reg;
                            res_fin_reg   <= pend_fin_reg;
                            res_err_reg   <= 1'b0;
                            res_last_reg  <= 1'b0;
                        end
                        pend_valid_reg <= 1'b1;
                        pend_node_reg  <= top_node_reg;
                        pend_disc_reg  <= top_disc_reg;
                        pend_fin_reg   <= time_reg + 8'd1;
                        if (sp_reg != '0)
                            state_reg <= S_POP;
                        else
                        begin
                            top_valid_reg <= 1'b0;
                            state_reg     <= S_STEP;
                        end
                    end
                end
                S_POP:
                begin
                    top_node_reg <= stk_rd.node;
                    top_cur_reg  <= stk_rd.cur;
                    top_disc_reg <= stk_rd.disc;
                    sp_reg       <= sp_reg - NODE_W'(1);
                    state_reg    <= S_STEP;
                end
                S_EDGE:
                begin
                    top_cur_reg <= pool_nxt;
                    tgt_reg     <= pool_tgt;
                    if (CNT_W'(pool_tgt) >= n_eff)
                    begin
                        // bad target: flush the held result, then the error beat
                        if (pend_valid_reg)
                        begin
                            res_valid_reg <= 1'b1;
                            res_node_reg  <= pend_node_reg;
                            res_disc_reg  <= pend_disc_reg;
                            res_fin_reg   <= pend_fin_reg;
                            res_err_reg   <= 1'b0;
                            res_last_reg  <= 1'b0;
                            state_reg     <= S_ERR;
                        end
                        else
                        begin
                            res_valid_reg <= 1'b1;
                            res_node_reg  <= top_node_reg;
                            res_disc_reg  <= top_disc_reg;
                            res_fin_reg   <= '0;
                            res_err_reg   <= 1'b1;
                            res_last_reg  <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                    end
                    else
                        state_reg <= S_TGT;
                end
                S_TGT:
                begin
                    if (col_now == COLOR_WHITE)
                    begin
                        push_node_reg <= tgt_reg;
                        state_reg     <= S_PUSH;
                    end
                    else
                        state_reg <= S_STEP;
                end
                S_ERR:
                begin
                    res_valid_reg <= 1'b1;
                    res_node_reg  <= top_node_reg;
                    res_disc_reg  <= top_disc_reg;
                    res_fin_reg   <= '0;
                    res_err_reg   <= 1'b1;
                    res_last_reg  <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // drive the ports
    assign busy          = (state_reg != S_IDLE);
    assign result_valid  = res_valid_reg;
    assign finished_node = res_node_reg;
    assign discover_time = res_disc_reg;
    assign finish_time   = res_fin_reg;
    assign error         = res_err_reg;
    assign last          = res_last_reg;

endmodule

>>> bench/dependency_graph_dfs_postorder_tb.sv
// Self-checking bench for the dependency graph walker: random graphs, searches and node counts.
module dependency_graph_dfs_postorder_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dgdfs_pkg::*;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] node;
        logic       flag;
        logic [5:0] target;
    } beat_t;

    typedef struct packed {
        logic [5:0] node;
        logic [7:0] disc;
        logic [7:0] fin;
        logic       err;
        logic       last;
    } finish_t;

    localparam int WATCHDOG = 200000;
    localparam int IDLE_DRAIN = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] kind = '0;
    logic [5:0] node_index = '0;
    logic is_formula = 1'b0;
    logic [5:0] target_index = '0;
    logic cfg_we = 1'b0;
    logic [6:0] cfg_data = '0;
    logic result_valid;
    logic [5:0] finished_node;
    logic [7:0] discover_time;
    logic [7:0] finish_time;
    logic error;
    logic last;

    dependency_graph_dfs_postorder i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .kind(kind), .node_index(node_index), .is_formula(is_formula),
        .target_index(target_index), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .result_valid(result_valid), .finished_node(finished_node),
        .discover_time(discover_time), .finish_time(finish_time),
        .error(error), .last(last)
    );

    always #4 clk = ~clk;

    // Graph shadow used for prediction
    int unsigned node_limit_cfg;
    bit          g_flag [MAX_NODES];
    int          g_head [MAX_NODES];
    int          g_tail [MAX_NODES];
    int          g_next [MAX_EDGES];
    int          g_tgt  [MAX_EDGES];
    int          g_used;

    beat_t   pending_beats[$];
    finish_t expected_finishes[$];
    int      fail_count = 0;
    int      searches_run = 0;
    int      results_seen = 0;
    int      error_runs = 0;
    int      idle_cycles = 0;
    bit      idle_enabled = 1'b1;
    bit      hold_sender = 1'b0;
    bit      timed_out = 1'b0;
    int      gap_left = 0;

    function automatic void wipe_graph();
        for (int i = 0; i < MAX_NODES; i++)
        begin
            g_flag[i] = 1'b0;
            g_head[i] = MAX_EDGES;
            g_tail[i] = MAX_EDGES;
        end
        g_used = 0;
    endfunction

    // Walk the shadow graph depth first and queue each finished node
    function automatic void predict_postorder();
        int   n;
        int   sp;
        int   k;
        int   clock_stamp;
        int   color [MAX_NODES];
        int   disc  [MAX_NODES];
        int   st_node [MAX_NODES];
        int   st_cur  [MAX_NODES];
        finish_t r;
        finish_t run_res[$];
        n = node_limit_cfg;
        if (n < 1) n = 1;
        if (n > MAX_NODES) n = MAX_NODES;
        sp = 0;
        k = 0;
        clock_stamp = 0;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            color[i] = 0;
            disc[i] = 0;
        end
        for (int root = 0; root < n; root++)
        begin
            if (color[root] != 0) continue;
            color[root] = 1;
            clock_stamp = (clock_stamp + 1) & 8'hFF;
            disc[root] = clock_stamp;
            st_node[sp] = root;
            st_cur[sp] = g_flag[root] ? g_head[root] : MAX_EDGES;
            sp++;
            while (sp > 0)
            begin
                int top;
                int nd;
                int cur;
                top = sp - 1;
                nd = st_node[top];
                cur = st_cur[top];
                if (cur < MAX_EDGES)
                begin
                    int t;
                    t = g_tgt[cur];
                    st_cur[top] = g_next[cur];
                    if (t >= n)
                    begin
                        // nodes finished so far go out first, then the error beat
                        foreach (run_res[i]) expected_finishes.push_back(run_res[i]);
                        r = '{node: 6'(nd), disc: 8'(disc[nd]), fin: 8'd0, err: 1'b1,
                              last: 1'b1};
                        expected_finishes.push_back(r);
                        error_runs++;
                        return;
                    end
                    if (color[t] == 0 && sp < MAX_NODES)
                    begin
                        color[t] = 1;
                        clock_stamp = (clock_stamp + 1) & 8'hFF;
                        disc[t] = clock_stamp;
                        st_node[sp] = t;
                        st_cur[sp] = g_flag[t] ? g_head[t] : MAX_EDGES;
                        sp++;
                    end
                end
                else
                begin
                    sp = top;
                    color[nd] = 2;
                    clock_stamp = (clock_stamp + 1) & 8'hFF;
                    if (k < MAX_NODES)
                    begin
                        r = '{node: 6'(nd), disc: 8'(disc[nd]), fin: 8'(clock_stamp),
                              err: 1'b0, last: 1'b0};
                        run_res.push_back(r);
                        k++;
                    end
                end
            end
        end
        if (run_res.size() > 0) run_res[run_res.size()-1].last = 1'b1;
        foreach (run_res[i]) expected_finishes.push_back(run_res[i]);
    endfunction

    // Apply one accepted beat to the shadow graph
    function automatic void model_beat(beat_t b);
        case (b.kind)
            KIND_FLAG: g_flag[b.node] = b.flag;
            KIND_EDGE:
                if (g_used < MAX_EDGES)
                begin
                    g_tgt[g_used] = b.target;
                    g_next[g_used] = MAX_EDGES;
                    if (g_tail[b.node] < MAX_EDGES) g_next[g_tail[b.node]] = g_used;
                    else g_head[b.node] = g_used;
                    g_tail[b.node] = g_used;
                    g_used++;
                end
            KIND_START:
            begin
                searches_run++;
                predict_postorder();
            end
            default: wipe_graph();
        endcase
    endfunction

    // Driver: present the next beat, hold it until the walker takes it
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                model_beat('{kind: kind, node: node_index, flag: is_formula,
                             target: target_index});
                idle_cycles = 0;
            end
            if (start && busy)
                ;
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (pending_beats.size() > 0 &&
                     !(hold_sender && (busy || expected_finishes.size() > 0)) &&
                     !(idle_enabled && $urandom_range(0, 7) == 0))
            begin
                beat_t b;
                b = pending_beats.pop_front();
                kind <= b.kind;
                node_index <= b.node;
                is_formula <= b.flag;
                target_index <= b.target;
                start <= 1'b1;
            end
            else
            begin
                if (idle_enabled && pending_beats.size() > 0 && !hold_sender)
                    gap_left <= $urandom_range(1, 10);
                start <= 1'b0;
            end
        end
    end

    // Monitor: compare each result strobe with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            finish_t want;
            idle_cycles = 0;
            results_seen++;
            if (expected_finishes.size() == 0)
            begin
                $display("%0t: unexpected result node=%0d disc=%0d fin=%0d err=%0b last=%0b",
                         $realtime, finished_node, discover_time, finish_time, error, last);
                fail_count++;
            end
            else
            begin
                want = expected_finishes.pop_front();
                if (finished_node !== want.node || discover_time !== want.disc ||
                    finish_time !== want.fin || error !== want.err || last !== want.last)
                begin
                    $display("%0t: expected node=%0d disc=%0d fin=%0d err=%0b last=%0b",
                             $realtime, want.node, want.disc, want.fin, want.err, want.last);
                    $display("%0t: actual   node=%0d disc=%0d fin=%0d err=%0b last=%0b",
                             $realtime, finished_node, discover_time, finish_time, error,
                             last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no accepted beat or result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles > WATCHDOG)
            begin
                timed_out = 1'b1;
                $display("%0t: no beat moved for %0d cycles", $realtime, WATCHDOG);
                $display("dependency_graph_dfs_postorder: mismatch");
                $finish;
            end
        end
    end

    function automatic beat_t mk(logic [1:0] k, int nd, int f, int t);
        beat_t b;
        b.kind = k;
        b.node = 6'(nd);
        b.flag = 1'(f);
        b.target = 6'(t);
        return b;
    endfunction

    // Wait for the walker to finish all queued work
    task automatic drain();
        wait (pending_beats.size() == 0 || timed_out);
        @(posedge clk);
        while ((start || busy || expected_finishes.size() > 0) && !timed_out)
            @(posedge clk);
        repeat (IDLE_DRAIN) @(posedge clk);
    endtask

    task automatic write_node_count(int v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= 7'(v);
        @(posedge clk);
        cfg_we <= 1'b0;
        node_limit_cfg = v;
    endtask

    // Queue a random graph over n nodes, with about bad_pct percent of edges aimed past it, then a search
    task automatic queue_graph(int n, int edges, int bad_pct);
        pending_beats.push_back(mk(KIND_CLEAR, $urandom_range(0, 63), $urandom_range(0, 1),
                                   $urandom_range(0, 63)));
        for (int i = 0; i < n; i++)
            if ($urandom_range(0, 3) != 0)
                pending_beats.push_back(mk(KIND_FLAG, i, 1, $urandom_range(0, 63)));
        for (int e = 0; e < edges; e++)
        begin
            int t;
            t = ($urandom_range(0, 99) < bad_pct) ? $urandom_range(n, 63)
                                                  : $urandom_range(0, n - 1);
            pending_beats.push_back(mk(KIND_EDGE, $urandom_range(0, n - 1),
                                       $urandom_range(0, 1), t));
        end
        pending_beats.push_back(mk(KIND_START, $urandom_range(0, 63), $urandom_range(0, 1),
                                   $urandom_range(0, 63)));
    endtask

    initial
    begin
        int sizes[6];
        node_limit_cfg = 64;
        wipe_graph();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: default node count, empty graph, flags and edges at extremes
        pending_beats.push_back(mk(KIND_START, 0, 0, 0));
        pending_beats.push_back(mk(KIND_FLAG, 0, 1, 63));
        pending_beats.push_back(mk(KIND_FLAG, 63, 1, 0));
        pending_beats.push_back(mk(KIND_FLAG, 5, 0, 0));
        pending_beats.push_back(mk(KIND_EDGE, 0, 0, 63));
        pending_beats.push_back(mk(KIND_EDGE, 0, 1, 1));
        pending_beats.push_back(mk(KIND_EDGE, 63, 0, 0));
        pending_beats.push_back(mk(KIND_EDGE, 5, 0, 2));
        pending_beats.push_back(mk(KIND_START, 63, 1, 63));
        drain();

        // Small node count: bad target ends the run early
        write_node_count(4);
        pending_beats.push_back(mk(KIND_CLEAR, 0, 0, 0));
        pending_beats.push_back(mk(KIND_FLAG, 1, 1, 0));
        pending_beats.push_back(mk(KIND_EDGE, 1, 0, 2));
        pending_beats.push_back(mk(KIND_EDGE, 1, 0, 9));
        pending_beats.push_back(mk(KIND_START, 0, 0, 0));
        drain();

        // Saturating counts: zero and above the maximum, plus one node
        write_node_count(0);
        pending_beats.push_back(mk(KIND_START, 0, 0, 0));
        drain();
        write_node_count(127);
        pending_beats.push_back(mk(KIND_CLEAR, 63, 1, 63));
        pending_beats.push_back(mk(KIND_START, 0, 0, 0));
        drain();
        write_node_count(1);
        pending_beats.push_back(mk(KIND_START, 0, 0, 0));
        drain();

        // Random graphs over a spread of node counts, one phase at the full count
        sizes = '{2, 3, 5, 8, 16, 64};
        for (int ph = 0; ph < 8; ph++)
        begin
            int n;
            int graphs;
            n = sizes[$urandom_range(0, 4)];
            graphs = 2;
            if (ph == 4)
            begin
                n = sizes[5];
                graphs = 1;
            end
            write_node_count(n);
            // hold every beat after a search until its results are all in
            if (ph == 3) hold_sender = 1'b1;
            if (ph >= 6) idle_enabled = 1'b0;
            for (int g = 0; g < graphs; g++)
                queue_graph(n, (n == 64) ? $urandom_range(0, 32) : $urandom_range(0, 2 * n),
                            (ph % 3 == 0) ? 6 : 0);
            drain();
            hold_sender = 1'b0;
        end

        if (timed_out)
            $display("dependency_graph_dfs_postorder: mismatch");
        else
        begin
            $display("covered %0d searches, %0d results checked, %0d runs ended on a bad edge",
                     searches_run, results_seen, error_runs);
            if (fail_count == 0 && expected_finishes.size() == 0)
                $display("dependency_graph_dfs_postorder: match");
            else
                $display("dependency_graph_dfs_postorder: mismatch");
        end
        $finish;
    end

endmodule
